// ----- rtl/cwac_pkg.sv -----
package cwac_pkg;

    localparam int NUM_SUBJECTS = 16;
    localparam int NUM_OBJECTS  = 256;
    localparam int NUM_FIRMS    = 16;
    localparam int NUM_CLASSES  = 8;
    localparam int REG_COUNT    = 8;

    localparam int SUBJ_AW = $clog2(NUM_SUBJECTS);
    localparam int OBJ_AW  = $clog2(NUM_OBJECTS);
    localparam int MASK_W  = 16;
    localparam int CFG_AW  = $clog2(REG_COUNT) + 2;
    localparam int REG_AW  = $clog2(REG_COUNT);

    typedef enum logic [2:0] {
        ACT_READ    = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_CLEAR   = 3'd2,
        ACT_DEF_SUBJ = 3'd3,
        ACT_DEF_OBJ = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_UNKNOWN  = 2'd1,
        STS_CONFLICT = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] subj_idx;
        logic [7:0] obj_idx;
        logic [3:0] firm_id;
    } t_item;

    typedef struct packed {
        logic       granted;
        logic [1:0] status;
        logic [3:0] accessed_firm;
    } t_result;

    typedef logic [REG_COUNT-1:0][MASK_W-1:0] t_class_masks;

    typedef struct packed {
        logic               rd_en;
        logic [SUBJ_AW-1:0] rd_addr;
        logic               wr_en;
        logic [SUBJ_AW-1:0] wr_addr;
        logic [MASK_W-1:0]  wr_data;
        logic               clear;
    } t_hist_ctl;

    typedef struct packed {
        logic              rd_en;
        logic [OBJ_AW-1:0] rd_addr;
        logic              wr_en;
        logic [OBJ_AW-1:0] wr_addr;
        logic [3:0]        wr_owner;
    } t_obj_ctl;

    typedef struct packed {
        logic       known;
        logic [3:0] owner;
    } t_obj_rd;

endpackage

// ----- rtl/cwac_cfg.sv -----
module cwac_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cwac_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output cwac_pkg::t_class_masks     o_masks
);
    import cwac_pkg::*;

    t_class_masks        r_masks;
    logic [REG_AW-1:0]   idx;

    assign idx    = paddr[CFG_AW-1:2];
    assign pready = 1'b1;
    assign prdata = {{(32-MASK_W){1'b0}}, r_masks[idx]};
    assign o_masks = r_masks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks <= '0;
        end else if (psel && penable && pwrite) begin
            r_masks[idx] <= pwdata[MASK_W-1:0];
        end
    end

endmodule

// ----- rtl/cwac_obj_mem.sv -----
module cwac_obj_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cwac_pkg::t_obj_ctl  i_ctl,
    output cwac_pkg::t_obj_rd   o_rd
);
    import cwac_pkg::*;

    logic [3:0]             r_owner [NUM_OBJECTS];
    logic [NUM_OBJECTS-1:0] r_known;
    t_obj_rd                r_rd;

    assign o_rd = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_owner[i_ctl.wr_addr] <= i_ctl.wr_owner;
        end
        if (i_ctl.rd_en) begin
            r_rd.owner <= r_owner[i_ctl.rd_addr];
            r_rd.known <= r_known[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
        end else if (i_ctl.wr_en) begin
            r_known[i_ctl.wr_addr] <= 1'b1;
        end
    end

endmodule

// ----- rtl/cwac_hist_mem.sv -----
module cwac_hist_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cwac_pkg::t_hist_ctl         i_ctl,
    output logic [cwac_pkg::MASK_W-1:0] o_seen
);
    import cwac_pkg::*;

    logic [MASK_W-1:0]       r_mem [NUM_SUBJECTS];
    logic [NUM_SUBJECTS-1:0] r_valid;
    logic [MASK_W-1:0]       r_data;
    logic                    r_data_valid;

    // entry not valid reads as an empty history
    assign o_seen = r_data_valid ? r_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_data <= r_mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_data_valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_data_valid <= r_valid[i_ctl.rd_addr];
            end
        end
    end

endmodule

// ----- rtl/conflict_of_interest_access_check.sv -----
// Chinese Wall access checker.
// Input word: i_item (action, subject, object, firm) is taken at a rising edge
// with start high and busy low. busy is then high while in ST_EXEC, in which the
// object table and subject history are read and updated.
// Result word: o_result is marked by o_done, which is high for exactly one cycle
// and rises at the same edge at which busy falls; the receiver cannot stall it.
// A word passes the ST_EXEC state and then the r_done register before o_done.
// No new word is taken while busy, which covers the read-modify-write of the
// history memory (read at accept, then check and write back in ST_EXEC).
// Configuration: APB port, class masks 0..7 at byte addresses 4*i, 16 bits
// each; the user must write them only while idle, the block does not enforce it. pready is always high.
// Reset (i_rst_n low, synchronous): class masks, subject and object valid bits
// and all histories clear at once; no clearing pass is needed and the block
// takes a word in the first cycle after reset.
module conflict_of_interest_access_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cwac_pkg::t_item             i_item,
    output logic                        o_done,
    output cwac_pkg::t_result           o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cwac_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cwac_pkg::*;

    t_state                  r_state, n_state;
    t_item                   r_item;
    t_result                 r_result, n_result;
    logic                    r_done, n_done;
    logic [NUM_SUBJECTS-1:0] r_subj_known;
    t_class_masks            masks;
    t_hist_ctl               hist_ctl;
    t_obj_ctl                obj_ctl;
    t_obj_rd                 obj_rd;
    logic [MASK_W-1:0]       seen;
    logic [MASK_W-1:0]       firm_bit;
    logic                    accept;
    logic                    subj_ok;
    logic                    obj_ok;
    logic                    firm_ok;
    logic                    conflict;
    logic                    subj_def;

    cwac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_masks (masks)
    );

    cwac_obj_mem u_obj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (obj_ctl),
        .o_rd    (obj_rd)
    );

    cwac_hist_mem u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hist_ctl),
        .o_seen  (seen)
    );

    assign busy     = (r_state == ST_EXEC);
    assign accept   = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    assign subj_ok  = (32'(r_item.subj_idx) < NUM_SUBJECTS);
    assign obj_ok   = (32'(r_item.obj_idx) < NUM_OBJECTS);
    assign firm_ok  = (32'(r_item.firm_id) < NUM_FIRMS);
    assign firm_bit = MASK_W'(1) << obj_rd.owner;

    always_comb begin
        conflict = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if ((masks[c] & firm_bit) != '0 && (masks[c] & seen & ~firm_bit) != '0) begin
                conflict = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_done       <= 1'b0;
            r_subj_known <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (subj_def) begin
                r_subj_known[r_item.subj_idx[SUBJ_AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = r_result;
        subj_def = 1'b0;

        obj_ctl.rd_en    = accept;
        obj_ctl.rd_addr  = i_item.obj_idx[OBJ_AW-1:0];
        obj_ctl.wr_en    = 1'b0;
        obj_ctl.wr_addr  = r_item.obj_idx[OBJ_AW-1:0];
        obj_ctl.wr_owner = r_item.firm_id;

        hist_ctl.rd_en   = accept;
        hist_ctl.rd_addr = i_item.subj_idx[SUBJ_AW-1:0];
        hist_ctl.wr_en   = 1'b0;
        hist_ctl.wr_addr = r_item.subj_idx[SUBJ_AW-1:0];
        hist_ctl.wr_data = seen | firm_bit;
        hist_ctl.clear   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state  = ST_IDLE;
                n_done   = 1'b1;
                n_result = '{granted: 1'b0, status: STS_OK, accessed_firm: 4'd0};
                case (r_item.action)
                    ACT_READ, ACT_WRITE: begin
                        if (!subj_ok || !obj_ok || !obj_rd.known
                            || !r_subj_known[r_item.subj_idx[SUBJ_AW-1:0]]) begin
                            n_result.status = STS_UNKNOWN;
                        end else if (conflict) begin
                            n_result.status = STS_CONFLICT;
                        end else begin
                            n_result.granted       = 1'b1;
                            n_result.accessed_firm = obj_rd.owner;
                            hist_ctl.wr_en         = 1'b1;
                        end
                    end
                    ACT_CLEAR: begin
                        n_result.granted = 1'b1;
                        hist_ctl.clear   = 1'b1;
                    end
                    ACT_DEF_SUBJ: begin
                        if (!subj_ok) begin
                            n_result.status = STS_UNKNOWN;
                        end else begin
                            n_result.granted = 1'b1;
                            subj_def         = 1'b1;
                        end
                    end
                    ACT_DEF_OBJ: begin
                        if (!obj_ok || !firm_ok) begin
                            n_result.status = STS_UNKNOWN;
                        end else begin
                            n_result.granted = 1'b1;
                            obj_ctl.wr_en    = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sim/tb_conflict_of_interest_access_check.sv -----
module tb_conflict_of_interest_access_check;
    import cwac_pkg::*;

    // codes with no name in the package
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    class wall_scoreboard;
        logic [MASK_W-1:0] class_masks [REG_COUNT];
        bit                subj_known  [NUM_SUBJECTS];
        bit                obj_known   [NUM_OBJECTS];
        logic [3:0]        obj_owner   [NUM_OBJECTS];
        logic [MASK_W-1:0] firms_seen  [NUM_SUBJECTS];
        t_result           verdict_q   [$];
        int                errors;
        int                n_checked;
        int                n_granted;
        int                n_conflict;
        int                n_unknown;

        function new();
            foreach (class_masks[i]) class_masks[i] = '0;
            foreach (subj_known[i]) subj_known[i] = 1'b0;
            foreach (obj_known[i]) obj_known[i] = 1'b0;
            foreach (firms_seen[i]) firms_seen[i] = '0;
            errors = 0;
            n_checked = 0;
            n_granted = 0;
            n_conflict = 0;
            n_unknown = 0;
        endfunction

        function void set_mask(input int idx, input logic [MASK_W-1:0] v);
            if (idx < REG_COUNT) class_masks[idx] = v;
        endfunction

        function bit wall_blocks(input logic [MASK_W-1:0] hist, input logic [3:0] firm);
            logic [MASK_W-1:0] fbit;
            fbit = MASK_W'(1) << firm;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if ((class_masks[c] & fbit) != 0 && (class_masks[c] & hist & ~fbit) != 0)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Work out the verdict for an accepted word and update the wall state.
        function void note_word(input t_item w);
            t_result    r;
            logic [3:0] f;
            r = '0;
            case (w.action)
                ACT_READ, ACT_WRITE: begin
                    if (!subj_known[w.subj_idx] || !obj_known[w.obj_idx]) begin
                        r.status = STS_UNKNOWN;
                        n_unknown++;
                    end else begin
                        f = obj_owner[w.obj_idx];
                        if (wall_blocks(firms_seen[w.subj_idx], f)) begin
                            r.status = STS_CONFLICT;
                            n_conflict++;
                        end else begin
                            firms_seen[w.subj_idx] |= MASK_W'(1) << f;
                            r.granted = 1'b1;
                            r.status = STS_OK;
                            r.accessed_firm = f;
                            n_granted++;
                        end
                    end
                end
                ACT_CLEAR: begin
                    foreach (firms_seen[i]) firms_seen[i] = '0;
                    r.granted = 1'b1;
                end
                ACT_DEF_SUBJ: begin
                    subj_known[w.subj_idx] = 1'b1;
                    r.granted = 1'b1;
                end
                ACT_DEF_OBJ: begin
                    obj_known[w.obj_idx] = 1'b1;
                    obj_owner[w.obj_idx] = w.firm_id;
                    r.granted = 1'b1;
                end
                default: ;
            endcase
            verdict_q = {verdict_q, r};
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endtask

        task check_word(input t_result r);
            t_result e;
            if (verdict_q.size() == 0) begin
                report($sformatf("result g=%b s=%0d f=%0d with nothing outstanding",
                                 r.granted, r.status, r.accessed_firm));
                return;
            end
            e = verdict_q.pop_front();
            n_checked++;
            if (r.granted !== e.granted)
                report($sformatf("word %0d granted %b, want %b", n_checked, r.granted,
                                 e.granted));
            if (r.status !== e.status)
                report($sformatf("word %0d status %0d, want %0d", n_checked, r.status,
                                 e.status));
            if (r.accessed_firm !== e.accessed_firm)
                report($sformatf("word %0d firm %0d, want %0d", n_checked,
                                 r.accessed_firm, e.accessed_firm));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    logic              o_done;
    t_result           o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    wall_scoreboard wall = new();
    int             n_settings = 0;

    conflict_of_interest_access_check i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3600000;
        $display("FAIL conflict_of_interest_access_check");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) wall.check_word(o_result);
    end

    task automatic send_word(input t_item w);
        start <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        wall.note_word(w);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (wall.pending() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_masks(input logic [MASK_W-1:0] m [REG_COUNT]);
        for (int i = 0; i < REG_COUNT; i++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= CFG_AW'(i * 4);
            pwdata <= {16'h0, m[i]};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            wall.set_mask(i, m[i]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        n_settings++;
    endtask

    function automatic int gap_len(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item mk_word(input logic [2:0] act, input int s, input int o,
                                      input int f);
        t_item w;
        w.action = act;
        w.subj_idx = 4'(s);
        w.obj_idx = 8'(o);
        w.firm_id = 4'(f);
        return w;
    endfunction

    // Mostly a small crowd of subjects and objects so histories and conflicts build up.
    function automatic t_item rand_word();
        t_item w;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 38)      w.action = ACT_READ;
        else if (r < 70) w.action = ACT_WRITE;
        else if (r < 73) w.action = ACT_CLEAR;
        else if (r < 82) w.action = ACT_DEF_SUBJ;
        else if (r < 96) w.action = ACT_DEF_OBJ;
        else             w.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        w.subj_idx = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 9))
                                                  : 4'($urandom_range(0, 15));
        w.obj_idx = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 19))
                                                 : 8'($urandom_range(0, 255));
        w.firm_id = 4'($urandom_range(0, 15));
        return w;
    endfunction

    initial begin
        logic [MASK_W-1:0] m [REG_COUNT];
        t_item             d [$];
        int                k;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // class 0 walls firms 0 and 15 apart, class 7 firms 1 and 2
        foreach (m[i]) m[i] = '0;
        m[0] = 16'h8001;
        m[7] = 16'h0006;
        write_masks(m);

        d = {d, mk_word(ACT_READ, 0, 0, 15)};
        d = {d, mk_word(ACT_DEF_SUBJ, 0, 0, 0)};
        d = {d, mk_word(ACT_READ, 0, 0, 0)};
        d = {d, mk_word(ACT_DEF_OBJ, 0, 0, 0)};
        d = {d, mk_word(ACT_DEF_OBJ, 0, 255, 15)};
        d = {d, mk_word(ACT_DEF_SUBJ, 15, 255, 15)};
        d = {d, mk_word(ACT_READ, 0, 0, 0)};
        d = {d, mk_word(ACT_WRITE, 0, 255, 0)};
        d = {d, mk_word(ACT_READ, 0, 0, 15)};
        d = {d, mk_word(ACT_DEF_OBJ, 0, 1, 1)};
        d = {d, mk_word(ACT_DEF_OBJ, 0, 2, 2)};
        d = {d, mk_word(ACT_WRITE, 15, 1, 0)};
        d = {d, mk_word(ACT_READ, 15, 2, 0)};
        d = {d, mk_word(ACT_READ, 15, 255, 0)};
        d = {d, mk_word(ACT_CLEAR, 15, 255, 15)};
        d = {d, mk_word(ACT_WRITE, 0, 255, 0)};
        d = {d, mk_word(ACT_DEF_OBJ, 0, 255, 1)};
        d = {d, mk_word(ACT_READ, 0, 255, 0)};
        d = {d, mk_word(ACT_READ, 1, 0, 0)};
        d = {d, mk_word(ACT_DEF_SUBJ, 15, 0, 0)};
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            d = {d, mk_word(3'(a), 15, 255, 15)};
        foreach (d[i]) begin
            send_word(d[i]);
            pause(gap_len(i < 8));
        end

        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            foreach (m[i]) begin
                case (phase)
                    0: m[i] = '0;
                    1: m[i] = '1;
                    2: m[i] = MASK_W'($urandom);
                    3: m[i] = MASK_W'($urandom & $urandom & $urandom);
                    default: begin
                        k = $urandom_range(0, 2);
                        m[i] = (k == 0) ? '0 : (k == 1) ? '1 : MASK_W'($urandom);
                    end
                endcase
            end
            write_masks(m);
            for (int i = 0; i < 350; i++) begin
                send_word(rand_word());
                if (phase == 2 && i == 175) wait_idle();
                else pause(gap_len((i % 120) < 30));
            end
        end

        wait_idle();
        if (wall.pending() != 0)
            wall.report($sformatf("%0d results never arrived", wall.pending()));
        $display("checked %0d words over %0d mask settings", wall.n_checked, n_settings);
        $display("accesses: %0d granted, %0d walled off, %0d unknown party",
                 wall.n_granted, wall.n_conflict, wall.n_unknown);
        if (wall.errors == 0) begin
            $display("PASS conflict_of_interest_access_check");
        end else begin
            $display("FAIL conflict_of_interest_access_check");
        end
        $finish;
    end
endmodule
